// File: hw/rtl/mtg_pkg.sv
// Shared types and constants for the Mersenne Twister word generator.
package mtg_pkg;

    // Store geometry and twist constants
    localparam int unsigned STORE_WORDS = 624;
    localparam int unsigned TAP_OFFSET  = 397;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned ADDR_W      = 10;

    localparam logic [WORD_W-1:0] TWIST_CONST = 32'h9908_B0DF;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;

    localparam t_addr LAST_ADDR  = t_addr'(STORE_WORDS - 1);
    localparam t_addr END_POS    = t_addr'(STORE_WORDS);
    localparam t_addr TAP_WRAP   = t_addr'(STORE_WORDS - TAP_OFFSET);
    localparam t_addr TAP_ADD    = t_addr'(TAP_OFFSET);

    // Operation codes of an input transaction
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_wr;   // write seed word, clear read position
        logic draw_rd;   // read word at read position, advance it
        logic prime;     // read word 0 ahead of the twist
        logic twist;     // one twist step: read taps, write previous word
        logic flush;     // write last twisted word, clear read position
        logic out_load;  // move read data into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_end;   // read position has reached the end of the store
        logic k_last;    // twist step counter at the last word
        logic out_full;  // output register holds an untaken word
    } t_status;

    // One twist step: upper bit of word k, lower bits of word k+1, tap word
    function automatic t_word mix_word(t_word hi_src, t_word lo_src, t_word tap);
        t_word y;
        t_word mag;
        y   = {hi_src[WORD_W-1], lo_src[WORD_W-2:0]};
        mag = y[0] ? TWIST_CONST : '0;
        return tap ^ (y >> 1) ^ mag;
    endfunction

endpackage

// File: hw/rtl/mtg_ctrl.sv
// Controller state machine for the Mersenne Twister word generator.
module mtg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_operation,
    input  logic             i_out_ready,
    input  mtg_pkg::t_status i_status,
    output logic             o_in_ready,
    output mtg_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_PRIME     = 6'b000010,
        ST_TWIST     = 6'b000100,
        ST_FLUSH     = 6'b001000,
        ST_DRAW_RD   = 6'b010000,
        ST_DRAW_WAIT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == mtg_pkg::OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else if (i_status.pos_end) begin
                        n_state = ST_PRIME;
                    end else begin
                        o_cmd.draw_rd = 1'b1;
                        n_state       = ST_DRAW_WAIT;
                    end
                end
            end
            ST_PRIME: begin
                o_cmd.prime = 1'b1;
                n_state     = ST_TWIST;
            end
            ST_TWIST: begin
                o_cmd.twist = 1'b1;
                if (i_status.k_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = ST_DRAW_RD;
            end
            ST_DRAW_RD: begin
                o_cmd.draw_rd = 1'b1;
                n_state       = ST_DRAW_WAIT;
            end
            ST_DRAW_WAIT: begin
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/mtg_datapath.sv
// Datapath: word store, read position, twist pipeline and output register.
module mtg_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtg_pkg::t_cmd    i_cmd,
    input  mtg_pkg::t_addr   i_word_index,
    input  mtg_pkg::t_word   i_seed_word,
    input  logic             i_out_ready,
    output mtg_pkg::t_status o_status,
    output logic             o_out_valid,
    output mtg_pkg::t_word   o_random_word
);

    // Store memory: one write port, two registered read ports
    mtg_pkg::t_word r_mem [mtg_pkg::STORE_WORDS];

    mtg_pkg::t_addr r_pos;
    mtg_pkg::t_addr r_k;
    mtg_pkg::t_word r_rd_a;
    mtg_pkg::t_word r_rd_b;
    mtg_pkg::t_word r_cur;
    mtg_pkg::t_word r_out;
    logic           r_out_valid;

    logic           rd_a_en;
    mtg_pkg::t_addr rd_a_addr;
    mtg_pkg::t_addr nxt_addr;
    mtg_pkg::t_addr tap_addr;
    logic           wr_en;
    mtg_pkg::t_addr wr_addr;
    mtg_pkg::t_word wr_data;
    logic           tw_wr;

    // Twist neighbour and tap addresses for step k
    assign nxt_addr = (r_k == mtg_pkg::LAST_ADDR) ? '0 : r_k + 1'b1;
    assign tap_addr = (r_k < mtg_pkg::TAP_WRAP) ? r_k + mtg_pkg::TAP_ADD
                                                : r_k - mtg_pkg::TAP_WRAP;

    // Read port A serves draws, the prime read and the neighbour word
    assign rd_a_en = i_cmd.draw_rd || i_cmd.prime || i_cmd.twist;
    always_comb begin
        rd_a_addr = nxt_addr;
        if (i_cmd.draw_rd) begin
            rd_a_addr = r_pos;
        end else if (i_cmd.prime) begin
            rd_a_addr = '0;
        end
    end

    // Write port: seed loads or the word of the previous twist step
    assign tw_wr = (i_cmd.twist && (r_k != '0)) || i_cmd.flush;
    always_comb begin
        if (tw_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_k - 1'b1;
            wr_data = mtg_pkg::mix_word(r_cur, r_rd_a, r_rd_b);
        end else begin
            wr_en   = i_cmd.load_wr && (i_word_index < mtg_pkg::END_POS);
            wr_addr = i_word_index;
            wr_data = i_seed_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            r_rd_a <= r_mem[rd_a_addr];
        end
        if (i_cmd.twist) begin
            r_rd_b <= r_mem[tap_addr];
        end
    end

    // Pre-update copy of word k: the neighbour read one step earlier
    always_ff @(posedge i_clk) begin
        if (i_cmd.twist) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.out_load) begin
            r_out <= r_rd_a;
        end
    end

    // Read position and twist step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_k   <= '0;
        end else begin
            if (i_cmd.load_wr || i_cmd.flush) begin
                r_pos <= '0;
            end else if (i_cmd.draw_rd) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.prime) begin
                r_k <= '0;
            end else if (i_cmd.twist) begin
                r_k <= r_k + 1'b1;
            end
        end
    end

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.pos_end  = (r_pos == mtg_pkg::END_POS);
    assign o_status.k_last   = (r_k == mtg_pkg::LAST_ADDR);
    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_random_word     = r_out;

    // Checks
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten before it was taken");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= mtg_pkg::END_POS)
        else $error("read position beyond end of store");

    a_draw_before_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.draw_rd |-> (r_pos != mtg_pkg::END_POS))
        else $error("draw read issued with exhausted store");

    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |-> (r_k == mtg_pkg::END_POS))
        else $error("twist flushed before all words were stepped");

    a_flush_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_pos == '0))
        else $error("read position not cleared after twist");

endmodule

// File: hw/rtl/mersenne_twister_generator.sv
// Mersenne Twister (MT19937, untempered) word generator: top level.
// A load transaction writes one seed word into the 624-word store and
// rewinds the read position; indices 624 and above write nothing but still rewind it.
// All 624 words must be loaded before the first draw. A draw transaction reads the store
// into a register on accept, then moves that word into the output register once the
// output side has taken any previous word. When a draw finds all 624 words used, the store
// is regenerated first: one word per cycle, set by the single write port of the store
// memory, with a prime read, a twist step per word and a flush write. Words are returned
// without tempering, so the first 624 draws after loading return the seeds as written.
module mersenne_twister_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [9:0]  i_word_index,
    input  logic [31:0] i_seed_word,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_random_word
);

    mtg_pkg::t_cmd    cmd;
    mtg_pkg::t_status status;

    mtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    mtg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word_index  (i_word_index),
        .i_seed_word   (i_seed_word),
        .i_out_ready   (i_out_ready),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_random_word (o_random_word)
    );

endmodule

// File: bench/tb.sv
// Self-checking testbench for the MT19937 word generator: scoreboard, drivers and watchdog.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 50;

    // Tracks the word store and read position, and queues the words due out
    class twister_scoreboard;
        mtg_pkg::t_word store_words[mtg_pkg::STORE_WORDS];
        int unsigned    draw_pos    = 0;
        int unsigned    error_count = 0;
        mtg_pkg::t_word words_due[$];

        // Regenerate the whole store in place; wrapped taps see updated words
        function void twist_store();
            mtg_pkg::t_word y;
            int unsigned    k;
            for (k = 0; k < mtg_pkg::STORE_WORDS; k++) begin
                y = {store_words[k][mtg_pkg::WORD_W-1],
                     store_words[(k + 1) % mtg_pkg::STORE_WORDS][mtg_pkg::WORD_W-2:0]};
                store_words[k] =
                    store_words[(k + mtg_pkg::TAP_OFFSET) % mtg_pkg::STORE_WORDS]
                    ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_CONST : mtg_pkg::t_word'(0));
            end
        endfunction

        // Accepted input transaction
        function void note_item(mtg_pkg::t_op op, mtg_pkg::t_addr idx, mtg_pkg::t_word seed);
            if (op == mtg_pkg::OP_LOAD) begin
                if (idx < mtg_pkg::STORE_WORDS) begin
                    store_words[idx] = seed;
                end
                draw_pos = 0;
            end else begin
                if (draw_pos >= mtg_pkg::STORE_WORDS) begin
                    twist_store();
                    draw_pos = 0;
                end
                words_due.push_back(store_words[draw_pos]);
                draw_pos++;
            end
        endfunction

        // Accepted output transaction
        function void check_word(mtg_pkg::t_word got);
            mtg_pkg::t_word want;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected random_word: expected none, actual %h", $time, got);
                error_count++;
            end else begin
                want = words_due.pop_front();
                if (got !== want) begin
                    $display("%0t: random_word mismatch: expected %h, actual %h",
                             $time, want, got);
                    error_count++;
                end
            end
        endfunction

        function int unsigned pending();
            return words_due.size();
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    mtg_pkg::t_op   in_op     = mtg_pkg::OP_LOAD;
    mtg_pkg::t_addr in_index  = '0;
    mtg_pkg::t_word in_seed   = '0;
    logic           out_ready = 1'b0;
    logic           in_ready;
    logic           out_valid;
    mtg_pkg::t_word out_word;

    twister_scoreboard sb;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned draws_left     = 630;
    int unsigned quiet_cycles   = 0;

    mersenne_twister_generator u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (in_op),
        .i_word_index  (in_index),
        .i_seed_word   (in_seed),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_random_word (out_word)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random back-pressure
    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.check_word(out_word);
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d words outstanding", $time, sb.pending());
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // One input transaction, with random idle cycles ahead of it
    task automatic send_item(input mtg_pkg::t_op op, input mtg_pkg::t_addr idx,
                             input mtg_pkg::t_word seed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_index <= idx;
        in_seed  <= seed;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        sb.note_item(op, idx, seed);
        @(negedge clk);
    endtask

    // Hold the sender off until every outstanding word has come out
    task automatic drain_words();
        in_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (sb.pending() != 0);
    endtask

    // Draw runs (about half long enough to cross a twist) broken by short bursts of loads
    task automatic run_random(input int unsigned count);
        int unsigned    n;
        int unsigned    burst;
        mtg_pkg::t_addr idx;
        mtg_pkg::t_word seed;
        n = 0;
        while (n < count) begin
            if (draws_left == 0) begin
                burst = $urandom_range(1, 4);
                repeat (burst) begin
                    if ($urandom_range(0, 7) == 0) begin
                        idx = mtg_pkg::t_addr'($urandom_range(mtg_pkg::STORE_WORDS, 1023));
                    end else begin
                        idx = mtg_pkg::t_addr'($urandom_range(0, mtg_pkg::STORE_WORDS - 1));
                    end
                    case ($urandom_range(0, 9))
                        0:       seed = '0;
                        1:       seed = '1;
                        default: seed = $urandom;
                    endcase
                    send_item(mtg_pkg::OP_LOAD, idx, seed);
                    n++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    draws_left = $urandom_range(mtg_pkg::STORE_WORDS + 1, 1400);
                end else begin
                    draws_left = $urandom_range(1, 200);
                end
            end else begin
                send_item(mtg_pkg::OP_DRAW, mtg_pkg::t_addr'($urandom_range(0, 1023)),
                          $urandom);
                draws_left--;
                n++;
            end
        end
    endtask

    initial begin
        int unsigned    load_order[mtg_pkg::STORE_WORDS];
        int unsigned    i;
        int unsigned    j;
        int unsigned    tmp;
        int unsigned    p;
        mtg_pkg::t_word seed;

        sb = new;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill every word before the first draw, in shuffled order
        for (i = 0; i < mtg_pkg::STORE_WORDS; i++) begin
            load_order[i] = i;
        end
        for (i = mtg_pkg::STORE_WORDS - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            tmp           = load_order[i];
            load_order[i] = load_order[j];
            load_order[j] = tmp;
        end
        for (i = 0; i < mtg_pkg::STORE_WORDS; i++) begin
            case (load_order[i])
                0:                        seed = '0;
                1:                        seed = 32'h8000_0000;
                2:                        seed = 32'h7FFF_FFFF;
                mtg_pkg::STORE_WORDS - 1: seed = '1;
                default:                  seed = $urandom;
            endcase
            send_item(mtg_pkg::OP_LOAD, mtg_pkg::t_addr'(load_order[i]), seed);
        end

        // Directed: raw seed words, out-of-range loads rewinding, rewrites at the ends
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_DRAW, '1, '1);
        send_item(mtg_pkg::OP_DRAW, mtg_pkg::LAST_ADDR, '1);
        send_item(mtg_pkg::OP_LOAD, '1, '1);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_LOAD, mtg_pkg::END_POS, 32'h1234_5678);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_LOAD, mtg_pkg::LAST_ADDR, '1);
        send_item(mtg_pkg::OP_LOAD, '0, '0);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_LOAD, mtg_pkg::t_addr'(2), 32'h7FFF_FFFF);
        send_item(mtg_pkg::OP_LOAD, mtg_pkg::t_addr'(1), 32'h8000_0000);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_DRAW, '0, '0);
        send_item(mtg_pkg::OP_DRAW, '0, '0);

        // Random phases with different idling on each side; the opening draw run
        // spans all phases and crosses the first twist
        for (p = 0; p < 4; p++) begin
            drain_words();
            case (p)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 87;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            run_random(160);
        end

        drain_words();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_ctrl.sv
hw/rtl/mtg_datapath.sv
hw/rtl/mersenne_twister_generator.sv
bench/tb.sv
